### rtl/core/max_frequency_stack_top_macros.svh
// Assertion macros shared by the frequency stack modules
`ifndef MAX_FREQUENCY_STACK_TOP_MACROS_SVH
`define MAX_FREQUENCY_STACK_TOP_MACROS_SVH
`ifndef SYNTH
// property that holds at every clock while out of reset
`define MFS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// antecedent in one cycle implies consequent in the next
`define MFS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define MFS_ASSERT(lbl, prop, msg)
`define MFS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### rtl/core/mfs_pkg.sv
// Shared constants, codes and command/status structs of the frequency stack
package mfs_pkg;

    localparam int CAPACITY_DEF = 256;
    localparam int DISTINCT_DEF = 64;
    localparam int VALUE_W      = 32;

    // command codes
    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    // result status codes
    typedef logic [1:0] status_t;
    localparam status_t ST_PUSH_OK = 2'd0;
    localparam status_t ST_POP_OK  = 2'd1;
    localparam status_t ST_EMPTY   = 2'd2;
    localparam status_t ST_FULL    = 2'd3;

    // controller to datapath
    typedef struct packed {
        logic    load;
        logic    scan_clr;
        logic    scan_rd;
        logic    scan_cmp;
        logic    cnt_rd;
        logic    push_cnt_wr;
        logic    push_link;
        logic    pop_top_rd;
        logic    pop_ent_rd;
        logic    pop_unlink;
        logic    pop_cnt_wr;
        logic    emit;
        status_t code;
    } mfs_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic full;
        logic empty;
        logic scan_last;
        logic hit;
        logic free_ok;
    } mfs_stat_t;

endpackage

### rtl/core/mfs_datapath.sv
// Datapath: count table, entry pool, level stacks and free chain
module mfs_datapath #(
    parameter int CAPACITY = mfs_pkg::CAPACITY_DEF,
    parameter int DISTINCT = mfs_pkg::DISTINCT_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic signed [mfs_pkg::VALUE_W-1:0]  push_value,
    input  mfs_pkg::mfs_cmd_t                   ctl,
    output mfs_pkg::mfs_stat_t                  stat,
    output logic                                done,
    output logic signed [mfs_pkg::VALUE_W-1:0]  popped_value,
    output mfs_pkg::status_t                    status
);
    import mfs_pkg::*;
`include "max_frequency_stack_top_macros.svh"

    localparam int EW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int SW = (DISTINCT > 1) ? $clog2(DISTINCT) : 1;

    // memories
    logic [VALUE_W-1:0] key_mem   [DISTINCT];
    logic [CW-1:0]      cnt_mem   [DISTINCT];
    logic [EW-1:0]      lt_mem    [CAPACITY];
    logic [VALUE_W-1:0] val_mem   [CAPACITY];
    logic [EW-1:0]      below_mem [CAPACITY];
    logic [CW-1:0]      fn_mem    [CAPACITY];

    logic [VALUE_W-1:0] key_rd_reg, val_rd_reg;
    logic [CW-1:0]      cnt_rd_reg, fn_rd_reg;
    logic [EW-1:0]      lt_rd_reg, below_rd_reg;

    logic signed [VALUE_W-1:0] key_reg;
    logic [SW-1:0]      scan_idx_reg, slot_reg;
    logic               hit_reg, free_ok_reg;
    logic [DISTINCT-1:0] used_reg;
    logic [CW-1:0]      cnt_reg, free_head_reg, hwm_reg, top_reg, total_reg;
    logic [EW-1:0]      e_reg;
    logic               done_reg;
    logic signed [VALUE_W-1:0] pop_out_reg;
    status_t            status_reg;

    logic [CW-1:0] cnt_new;
    logic [EW-1:0] lv_new, lv_push, lv_top, e_new;
    logic          hit_now, fresh;

    // combinational helpers
    assign hit_now = used_reg[scan_idx_reg] && (key_rd_reg == key_reg);
    assign cnt_new = hit_reg ? (cnt_rd_reg + CW'(1)) : CW'(1);
    assign lv_new  = EW'(cnt_new - CW'(1));
    assign lv_push = EW'(cnt_reg - CW'(1));
    assign lv_top  = EW'(top_reg - CW'(1));
    assign e_new   = free_head_reg[EW-1:0];
    assign fresh   = (free_head_reg == hwm_reg);

    assign stat.full      = (total_reg == CW'(CAPACITY));
    assign stat.empty     = (top_reg == '0);
    assign stat.scan_last = (scan_idx_reg == SW'(DISTINCT - 1));
    assign stat.hit       = hit_reg;
    assign stat.free_ok   = free_ok_reg;

    // count key memory
    always_ff @(posedge clk)
    begin
        if (ctl.push_cnt_wr && !hit_reg)
            key_mem[slot_reg] <= key_reg;
        if (ctl.scan_rd)
            key_rd_reg <= key_mem[scan_idx_reg];
    end

    // count memory
    always_ff @(posedge clk)
    begin
        if (ctl.push_cnt_wr)
            cnt_mem[slot_reg] <= cnt_new;
        else if (ctl.pop_cnt_wr)
            cnt_mem[slot_reg] <= cnt_rd_reg - CW'(1);
        if (ctl.cnt_rd)
            cnt_rd_reg <= cnt_mem[slot_reg];
    end

    // level top memory
    always_ff @(posedge clk)
    begin
        if (ctl.push_link)
            lt_mem[lv_push] <= e_new;
        else if (ctl.pop_unlink && (below_rd_reg != e_reg))
            lt_mem[lv_top] <= below_rd_reg;
        if (ctl.push_cnt_wr)
            lt_rd_reg <= lt_mem[lv_new];
        else if (ctl.pop_top_rd)
            lt_rd_reg <= lt_mem[lv_top];
    end

    // entry memory
    always_ff @(posedge clk)
    begin
        if (ctl.push_link)
        begin
            val_mem[e_new]   <= key_reg;
            below_mem[e_new] <= (cnt_reg <= top_reg) ? lt_rd_reg : e_new;
        end
        if (ctl.pop_ent_rd)
        begin
            val_rd_reg   <= val_mem[lt_rd_reg];
            below_rd_reg <= below_mem[lt_rd_reg];
        end
    end

    // free chain memory, its read value is used only for freed cells
    always_ff @(posedge clk)
    begin
        if (ctl.pop_unlink)
            fn_mem[e_reg] <= free_head_reg;
        if (ctl.push_cnt_wr)
            fn_rd_reg <= fn_mem[e_new];
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (ctl.load)
            key_reg <= push_value;
        else if (ctl.pop_unlink)
            key_reg <= val_rd_reg;
        if (ctl.push_cnt_wr)
            cnt_reg <= cnt_new;
        if (ctl.pop_ent_rd)
            e_reg <= lt_rd_reg;
        if (ctl.emit)
        begin
            pop_out_reg <= (ctl.code == ST_POP_OK) ? key_reg : '0;
            status_reg  <= ctl.code;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_idx_reg  <= '0;
            slot_reg      <= '0;
            hit_reg       <= 1'b0;
            free_ok_reg   <= 1'b0;
            used_reg      <= '0;
            free_head_reg <= '0;
            hwm_reg       <= '0;
            top_reg       <= '0;
            total_reg     <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            done_reg <= ctl.emit;
            if (ctl.load || ctl.scan_clr)
            begin
                scan_idx_reg <= '0;
                hit_reg      <= 1'b0;
                free_ok_reg  <= 1'b0;
            end
            else if (ctl.scan_cmp)
            begin
                scan_idx_reg <= scan_idx_reg + SW'(1);
                if (hit_now)
                begin
                    slot_reg <= scan_idx_reg;
                    hit_reg  <= 1'b1;
                end
                else if (!used_reg[scan_idx_reg] && !free_ok_reg && !hit_reg)
                begin
                    slot_reg    <= scan_idx_reg;
                    free_ok_reg <= 1'b1;
                end
            end
            if (ctl.push_cnt_wr && !hit_reg)
                used_reg[slot_reg] <= 1'b1;
            if (ctl.pop_cnt_wr && (cnt_rd_reg == CW'(1)))
                used_reg[slot_reg] <= 1'b0;
            if (ctl.push_link)
            begin
                free_head_reg <= fresh ? (free_head_reg + CW'(1)) : fn_rd_reg;
                if (fresh)
                    hwm_reg <= hwm_reg + CW'(1);
                if (cnt_reg > top_reg)
                    top_reg <= cnt_reg;
                total_reg <= total_reg + CW'(1);
            end
            if (ctl.pop_unlink)
            begin
                free_head_reg <= {{(CW-EW){1'b0}}, e_reg};
                if (below_rd_reg == e_reg)
                    top_reg <= top_reg - CW'(1);
                total_reg <= total_reg - CW'(1);
            end
        end
    end

    assign done         = done_reg;
    assign popped_value = pop_out_reg;
    assign status       = status_reg;

    `MFS_ASSERT(a_total_bound, total_reg <= CW'(CAPACITY), "stored total beyond capacity")
    `MFS_ASSERT(a_top_bound, top_reg <= total_reg, "top level above stored total")
    `MFS_ASSERT_NEXT(a_link_grows, ctl.push_link, total_reg == $past(total_reg) + CW'(1), "push did not grow total")
endmodule

### rtl/core/mfs_ctrl.sv
// Controller: sequences the scan, count update and stack linking or unlinking per word
module mfs_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               cmd,
    input  mfs_pkg::mfs_stat_t stat,
    output mfs_pkg::mfs_cmd_t  ctl,
    output logic               busy
);
    import mfs_pkg::*;
`include "max_frequency_stack_top_macros.svh"

    typedef enum logic [11:0] {
        S_IDLE    = 12'b000000000001,
        S_SCAN_RD = 12'b000000000010,
        S_SCAN_CM = 12'b000000000100,
        S_DECIDE  = 12'b000000001000,
        S_CNT_RD  = 12'b000000010000,
        S_CNT_WR  = 12'b000000100000,
        S_LINK    = 12'b000001000000,
        S_TOP_RD  = 12'b000010000000,
        S_ENT_RD  = 12'b000100000000,
        S_UNLINK  = 12'b001000000000,
        S_POP_DEC = 12'b010000000000,
        S_DONE    = 12'b100000000000
    } state_t;

    state_t  state_reg, state_next;
    logic    is_pop_reg, is_pop_next;
    status_t code_reg, code_next;

    // next state and commands
    always_comb
    begin
        state_next  = state_reg;
        is_pop_next = is_pop_reg;
        code_next   = code_reg;
        ctl         = '0;
        ctl.code    = code_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctl.load    = 1'b1;
                    is_pop_next = (cmd == CMD_POP);
                    if (cmd == CMD_POP)
                    begin
                        if (stat.empty)
                        begin
                            code_next  = ST_EMPTY;
                            state_next = S_DONE;
                        end
                        else
                            state_next = S_TOP_RD;
                    end
                    else if (stat.full)
                    begin
                        code_next  = ST_FULL;
                        state_next = S_DONE;
                    end
                    else
                        state_next = S_SCAN_RD;
                end
            end
            S_SCAN_RD:
            begin
                ctl.scan_rd = 1'b1;
                state_next  = S_SCAN_CM;
            end
            S_SCAN_CM:
            begin
                ctl.scan_cmp = 1'b1;
                state_next   = stat.scan_last ? S_DECIDE : S_SCAN_RD;
            end
            S_DECIDE:
            begin
                if (stat.hit)
                    state_next = S_CNT_RD;
                else if (is_pop_reg)
                begin
                    code_next  = ST_POP_OK;
                    state_next = S_DONE;
                end
                else if (stat.free_ok)
                    state_next = S_CNT_WR;
                else
                begin
                    code_next  = ST_FULL;
                    state_next = S_DONE;
                end
            end
            S_CNT_RD:
            begin
                ctl.cnt_rd = 1'b1;
                state_next = is_pop_reg ? S_POP_DEC : S_CNT_WR;
            end
            S_CNT_WR:
            begin
                ctl.push_cnt_wr = 1'b1;
                state_next      = S_LINK;
            end
            S_LINK:
            begin
                ctl.push_link = 1'b1;
                code_next     = ST_PUSH_OK;
                state_next    = S_DONE;
            end
            S_TOP_RD:
            begin
                ctl.pop_top_rd = 1'b1;
                state_next     = S_ENT_RD;
            end
            S_ENT_RD:
            begin
                ctl.pop_ent_rd = 1'b1;
                state_next     = S_UNLINK;
            end
            S_UNLINK:
            begin
                ctl.pop_unlink = 1'b1;
                ctl.scan_clr   = 1'b1;
                state_next     = S_SCAN_RD;
            end
            S_POP_DEC:
            begin
                ctl.pop_cnt_wr = 1'b1;
                code_next      = ST_POP_OK;
                state_next     = S_DONE;
            end
            S_DONE:
            begin
                ctl.emit   = 1'b1;
                state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            is_pop_reg <= 1'b0;
            code_reg   <= ST_PUSH_OK;
        end
        else
        begin
            state_reg  <= state_next;
            is_pop_reg <= is_pop_next;
            code_reg   <= code_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    `MFS_ASSERT_NEXT(a_emit_idle, ctl.emit, !busy, "not idle after result")
    `MFS_ASSERT_NEXT(a_start_busy, start && !busy, busy, "accepted word did not start work")
endmodule

### rtl/core/max_frequency_stack_top.sv
// Maximum-frequency stack: push values, pop the most frequent most recent one.
// One word at a time: start is taken while busy is low. A push into a full
// pool or a pop on empty goes from the accepting state straight to the done
// state; any other word walks the count-key table one slot at a time, a read
// then a compare, through its single-port memory, and a push may be refused
// there for want of a free count slot. Each word gives exactly one result,
// shown for one cycle with done high; the receiver cannot stall it, and the
// next word may be taken in that same cycle. No clearing pass is needed
// after reset.
module max_frequency_stack_top #(
    parameter int CAPACITY = mfs_pkg::CAPACITY_DEF,
    parameter int DISTINCT = mfs_pkg::DISTINCT_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               cmd,
    input  logic signed [mfs_pkg::VALUE_W-1:0] push_value,
    output logic                               done,
    output logic signed [mfs_pkg::VALUE_W-1:0] popped_value,
    output logic [1:0]                         status
);
    import mfs_pkg::*;

    mfs_cmd_t  ctl;
    mfs_stat_t stat;

    mfs_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .cmd   (cmd),
        .stat  (stat),
        .ctl   (ctl),
        .busy  (busy)
    );

    mfs_datapath #(
        .CAPACITY (CAPACITY),
        .DISTINCT (DISTINCT)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .push_value   (push_value),
        .ctl          (ctl),
        .stat         (stat),
        .done         (done),
        .popped_value (popped_value),
        .status       (status)
    );
endmodule
